@@ sv/set_assoc_lru_cache_controller_defines.svh @@
// Assertion macros used by the cache controller top file.
`ifndef SET_ASSOC_LRU_CACHE_CONTROLLER_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_CONTROLLER_DEFINES_SVH
`ifndef ASSERT_OFF
// Check that cons holds in the same cycle as ante.
`define SALC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("cache controller check failed");
// Check that cons holds in the cycle after ante.
`define SALC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("cache controller check failed");
`else
`define SALC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define SALC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/salc_pkg.sv @@
package salc_pkg;
	localparam int DEF_SET_COUNT = 256;
	localparam int DEF_WAY_COUNT = 8;
	localparam int SET_FIELD_W = 12;

	localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
	localparam logic [1:0] CFG_SET_BITS = 2'd1;
	localparam logic [1:0] CFG_WAY_BITS = 2'd2;
	localparam logic [1:0] CFG_WRITE_ALLOC = 2'd3;

	localparam logic [4:0] RST_OFFSET_BITS = 5'd5;
	localparam logic [3:0] RST_SET_BITS = 4'd6;
	localparam logic [1:0] RST_WAY_BITS = 2'd1;
	localparam logic RST_WRITE_ALLOC = 1'b1;
	localparam logic [4:0] MAX_OFFSET_BITS = 5'd16;

	localparam logic FUNC_WRITE = 1'b1;

	// Geometry after saturation.
	typedef struct packed {
		logic [4:0] ob;
		logic [3:0] sb;
		logic [1:0] wb;
		logic       wa;
	} cfg_t;

	typedef struct packed {
		logic                   func;
		logic [SET_FIELD_W-1:0] set;
		logic [31:0]            tag;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic        allocated;
		logic        evict_dirty;
		logic [31:0] evict_address;
		logic [2:0]  way_used;
	} res_t;
endpackage

@@ sv/set_assoc_lru_cache_controller.sv @@
// Set-associative write-back cache controller with LRU replacement. Each request
// (func 0 read, 1 write; 32-bit byte address) yields one result: hit, whether a
// line was allocated, whether a dirty victim must be written back and its block
// address, and the way hit or filled. A front stage splits the address by the
// configured geometry into a two-deep request queue; the back end serves one
// request at a time: it first reads the set row from the set memories, then
// compares the ways, picks the fill or victim way and writes the row back. The
// write-back stalls while the result register is held by out_ready low. After
// reset the back end clears the valid, dirty and rank memories one set per
// cycle, through all SET_COUNT sets, during which in_ready stays low. Write the
// config registers only while idle; oversized set and way values saturate to
// what SET_COUNT and WAY_COUNT support, offset bits to MAX_OFFSET_BITS.
`include "set_assoc_lru_cache_controller_defines.svh"
module set_assoc_lru_cache_controller #(
	parameter int SET_COUNT = salc_pkg::DEF_SET_COUNT,
	parameter int WAY_COUNT = salc_pkg::DEF_WAY_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [31:0] address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic        allocated,
	output logic        evict_dirty,
	output logic [31:0] evict_address,
	output logic [2:0]  way_used
);
	import salc_pkg::*;

	// Largest usable log2 of set and way counts.
	localparam int SMAX = $clog2(SET_COUNT + 1) - 1;
	localparam int WMAX = $clog2(WAY_COUNT + 1) - 1;

	logic [4:0] offset_bits_q;
	logic [3:0] set_bits_q;
	logic [1:0] way_bits_q;
	logic       write_alloc_q;
	cfg_t       cfg;
	req_t       head;
	logic       head_valid;
	logic       pop;
	logic       clearing;
	res_t       res;

	// Take config writes; unknown indexes are never reached with a 2-bit index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= RST_OFFSET_BITS;
			set_bits_q <= RST_SET_BITS;
			way_bits_q <= RST_WAY_BITS;
			write_alloc_q <= RST_WRITE_ALLOC;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
				CFG_SET_BITS:    set_bits_q <= cfg_data[3:0];
				CFG_WAY_BITS:    way_bits_q <= cfg_data[1:0];
				CFG_WRITE_ALLOC: write_alloc_q <= cfg_data[0];
			endcase
		end
	end

	// Saturate geometry: offset bits to MAX_OFFSET_BITS, set and way bits to what the memories hold.
	always_comb begin
		cfg.ob = (offset_bits_q > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_bits_q;
		cfg.sb = (set_bits_q > 4'(SMAX)) ? 4'(SMAX) : set_bits_q;
		cfg.wb = (3'(way_bits_q) > 3'(WMAX)) ? 2'(WMAX) : way_bits_q;
		cfg.wa = write_alloc_q;
	end

	salc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.hold       (clearing),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.address    (address),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	salc_back #(
		.SET_COUNT (SET_COUNT),
		.WAY_COUNT (WAY_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.clearing   (clearing),
		.res        (res),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

	assign hit = res.hit;
	assign allocated = res.allocated;
	assign evict_dirty = res.evict_dirty;
	assign evict_address = res.evict_address;
	assign way_used = res.way_used;

	`SALC_ASSERT_NOW(a_no_take_clr, clk, arst_n, in_valid && in_ready, !clearing)
	`SALC_ASSERT_NOW(a_hit_no_alloc, clk, arst_n, out_valid, !(hit && allocated))
	`SALC_ASSERT_NOW(a_evict_on_alloc, clk, arst_n, out_valid && evict_dirty, allocated)
	`SALC_ASSERT_NEXT(a_pop_nonempty, clk, arst_n, pop, !clearing)
endmodule

@@ sv/salc_front.sv @@
module salc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  salc_pkg::cfg_t      cfg,
	input  logic                hold,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic [31:0]         address,
	output salc_pkg::req_t      head,
	output logic                head_valid,
	input  logic                pop
);
	import salc_pkg::*;

	req_t       q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	req_t       req_in;
	logic [5:0] shamt;
	logic [31:0] set_full;
	logic       push;

	// Split the address under the current geometry.
	always_comb begin
		shamt = 6'(cfg.ob) + 6'(cfg.sb);
		set_full = (address >> cfg.ob) & ((32'd1 << cfg.sb) - 32'd1);
		req_in.func = func;
		req_in.set = set_full[SET_FIELD_W-1:0];
		req_in.tag = address >> shamt;
	end

	assign in_ready = (cnt_q != 2'd2) && !hold;
	assign push = in_valid && in_ready;
	assign head = q_q[rd_ptr_q];
	assign head_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

@@ sv/salc_back.sv @@
module salc_back #(
	parameter int SET_COUNT = salc_pkg::DEF_SET_COUNT,
	parameter int WAY_COUNT = salc_pkg::DEF_WAY_COUNT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  salc_pkg::cfg_t cfg,
	input  salc_pkg::req_t head,
	input  logic           head_valid,
	output logic           pop,
	output logic           clearing,
	output salc_pkg::res_t res,
	output logic           out_valid,
	input  logic           out_ready
);
	import salc_pkg::*;

	localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int WAY_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
	localparam logic [1:0] ST_CLR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_LOOK = 2'd2;

	logic [WAY_COUNT-1:0]            vmem [SET_COUNT];
	logic [WAY_COUNT-1:0]            dmem [SET_COUNT];
	logic [WAY_COUNT-1:0][3:0]       rmem [SET_COUNT];
	logic [WAY_COUNT-1:0][31:0]      tmem [SET_COUNT];

	logic [WAY_COUNT-1:0]            v_rd_q;
	logic [WAY_COUNT-1:0]            d_rd_q;
	logic [WAY_COUNT-1:0][3:0]       r_rd_q;
	logic [WAY_COUNT-1:0][31:0]      t_rd_q;

	logic [1:0]       state_q;
	logic [SET_W-1:0] clr_cnt_q;
	logic             out_valid_q;
	req_t             req_q;
	res_t             res_q;

	logic [SET_W-1:0] rd_addr;
	logic [SET_W-1:0] cur_set;
	logic             commit;
	logic             meta_we;
	logic [SET_W-1:0] meta_wa;

	logic [WAY_COUNT-1:0]       nv;
	logic [WAY_COUNT-1:0]       nd;
	logic [WAY_COUNT-1:0][3:0]  nr;
	logic [WAY_COUNT-1:0][31:0] nt;
	logic                       tag_we;
	res_t                       res_d;

	assign clearing = (state_q == ST_CLR);
	assign pop = (state_q == ST_IDLE) && head_valid;
	assign commit = (state_q == ST_LOOK) && (!out_valid_q || out_ready);
	assign cur_set = req_q.set[SET_W-1:0];
	assign rd_addr = (state_q == ST_LOOK) ? cur_set : head.set[SET_W-1:0];
	assign meta_we = clearing || commit;
	assign meta_wa = clearing ? clr_cnt_q : cur_set;
	assign res = res_q;
	assign out_valid = out_valid_q;

	// Lookup, replacement choice and rank update for the held request.
	always_comb begin
		logic [WAY_COUNT-1:0] inuse;
		logic [WAY_COUNT-1:0] vld;
		logic [WAY_COUNT-1:0] hitv;
		logic [4:0]           nvalid;
		logic [4:0]           hitway;
		logic [4:0]           empty;
		logic                 has_empty;
		logic [4:0]           victim;
		logic [3:0]           best;
		logic [4:0]           touch;
		logic [3:0]           trank;
		logic                 do_touch;
		logic                 alloc;
		logic [5:0]           shamt;
		logic [31:0]          old_tag;
		inuse = '0;
		vld = '0;
		hitv = '0;
		hitway = '0;
		empty = '0;
		has_empty = 1'b0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			inuse[w] = (5'(w) < (5'd1 << cfg.wb));
			vld[w] = v_rd_q[w] && inuse[w];
			hitv[w] = vld[w] && (t_rd_q[w] == req_q.tag);
		end
		nvalid = 5'($countones(vld));
		for (int w = WAY_COUNT - 1; w >= 0; w--) begin
			if (hitv[w]) begin
				hitway = 5'(w);
			end
			if (inuse[w] && !v_rd_q[w]) begin
				empty = 5'(w);
				has_empty = 1'b1;
			end
		end
		victim = '0;
		best = r_rd_q[0];
		for (int w = 1; w < WAY_COUNT; w++) begin
			if (inuse[w] && (r_rd_q[w] < best)) begin
				victim = 5'(w);
				best = r_rd_q[w];
			end
		end

		res_d.hit = |hitv;
		alloc = !res_d.hit && ((req_q.func != FUNC_WRITE) || cfg.wa);
		res_d.allocated = alloc;
		do_touch = res_d.hit || (alloc && !has_empty);
		touch = res_d.hit ? hitway : victim;
		trank = r_rd_q[touch[WAY_W-1:0]];

		nv = v_rd_q;
		nd = d_rd_q;
		nr = r_rd_q;
		nt = t_rd_q;
		tag_we = 1'b0;
		res_d.evict_dirty = 1'b0;
		res_d.evict_address = '0;
		res_d.way_used = '0;
		shamt = 6'(cfg.ob) + 6'(cfg.sb);
		old_tag = t_rd_q[victim[WAY_W-1:0]];

		if (do_touch) begin
			for (int w = 0; w < WAY_COUNT; w++) begin
				if ((5'(w) != touch) && vld[w] && (r_rd_q[w] > trank)) begin
					nr[w] = r_rd_q[w] - 4'd1;
				end
			end
			nr[touch[WAY_W-1:0]] = 4'(nvalid - 5'd1);
		end
		if (res_d.hit) begin
			if (req_q.func == FUNC_WRITE) begin
				nd[hitway[WAY_W-1:0]] = 1'b1;
			end
			res_d.way_used = hitway[2:0];
		end else if (alloc && has_empty) begin
			nv[empty[WAY_W-1:0]] = 1'b1;
			nd[empty[WAY_W-1:0]] = (req_q.func == FUNC_WRITE);
			nr[empty[WAY_W-1:0]] = nvalid[3:0];
			nt[empty[WAY_W-1:0]] = req_q.tag;
			tag_we = 1'b1;
			res_d.way_used = empty[2:0];
		end else if (alloc) begin
			if (d_rd_q[victim[WAY_W-1:0]]) begin
				res_d.evict_dirty = 1'b1;
				res_d.evict_address = (old_tag << shamt) |
					(32'(req_q.set) << cfg.ob);
			end
			nd[victim[WAY_W-1:0]] = (req_q.func == FUNC_WRITE);
			nt[victim[WAY_W-1:0]] = req_q.tag;
			tag_we = 1'b1;
			res_d.way_used = victim[2:0];
		end
	end

	// Set memories: one row per set, registered read.
	always_ff @(posedge clk) begin
		if (meta_we) begin
			vmem[meta_wa] <= clearing ? '0 : nv;
			dmem[meta_wa] <= clearing ? '0 : nd;
			rmem[meta_wa] <= clearing ? '0 : nr;
		end
		if (commit && tag_we) begin
			tmem[cur_set] <= nt;
		end
		v_rd_q <= vmem[rd_addr];
		d_rd_q <= dmem[rd_addr];
		r_rd_q <= rmem[rd_addr];
		t_rd_q <= tmem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			req_q <= head;
		end
		if (commit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + SET_W'(1);
					if (clr_cnt_q == SET_W'(SET_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

@@ tb/sv/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import salc_pkg::*;

	localparam logic FUNC_READ = 1'b0;
	localparam int   LINES = DEF_SET_COUNT * DEF_WAY_COUNT;
	localparam int   CYCLE_LIMIT = 400000;

	// Cache model plus queue of pending lookup outcomes.
	class cache_scoreboard;
		logic [31:0] tags [LINES];
		bit          valid [LINES];
		bit          dirty [LINES];
		logic [3:0]  rank [LINES];
		int          offset_r, sets_r, ways_r, walloc_r;
		res_t        pending [$];
		int          errors;

		function new();
			foreach (valid[i]) begin
				valid[i] = 0;
				dirty[i] = 0;
				rank[i] = 0;
				tags[i] = 0;
			end
			offset_r = RST_OFFSET_BITS;
			sets_r = RST_SET_BITS;
			ways_r = RST_WAY_BITS;
			walloc_r = RST_WRITE_ALLOC;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [4:0] val);
			case (idx)
				CFG_OFFSET_BITS: offset_r = val;
				CFG_SET_BITS:    sets_r = val[3:0];
				CFG_WAY_BITS:    ways_r = val[1:0];
				CFG_WRITE_ALLOC: walloc_r = val[0];
			endcase
		endfunction

		// Run one access through the model and queue its outcome.
		function void note_request(logic f, logic [31:0] a);
			int ob, sb, ways, set, base, nvalid, hitway, empty, victim, e;
			logic [31:0] tag;
			logic [3:0] r;
			res_t x;
			ob = offset_r > 16 ? 16 : offset_r;
			sb = sets_r > 8 ? 8 : sets_r;
			ways = 1 << ways_r;
			set = (a >> ob) & ((1 << sb) - 1);
			tag = 32'(64'(a) >> (ob + sb));
			base = set * DEF_WAY_COUNT;
			nvalid = 0;
			hitway = -1;
			empty = ways;
			x = '0;
			for (int w = 0; w < ways; w++) begin
				if (valid[base + w]) begin
					nvalid++;
					if (hitway < 0 && tags[base + w] == tag) hitway = w;
				end else if (empty == ways) begin
					empty = w;
				end
			end
			if (hitway >= 0) begin
				e = base + hitway;
				r = rank[e];
				for (int w = 0; w < ways; w++)
					if (w != hitway && valid[base + w] && rank[base + w] > r)
						rank[base + w] = rank[base + w] - 1;
				rank[e] = 4'(nvalid - 1);
				if (f == FUNC_WRITE) dirty[e] = 1;
				x.hit = 1;
				x.way_used = 3'(hitway);
			end else if (f == FUNC_READ || walloc_r != 0) begin
				x.allocated = 1;
				if (empty < ways) begin
					e = base + empty;
					tags[e] = tag;
					valid[e] = 1;
					dirty[e] = (f == FUNC_WRITE);
					rank[e] = 4'(nvalid);
					x.way_used = 3'(empty);
				end else begin
					victim = 0;
					for (int w = 1; w < ways; w++)
						if (rank[base + w] < rank[base + victim]) victim = w;
					e = base + victim;
					if (dirty[e]) begin
						x.evict_dirty = 1;
						x.evict_address = 32'((64'(tags[e]) << (ob + sb)) |
							(64'(set) << ob));
					end
					r = rank[e];
					for (int w = 0; w < ways; w++)
						if (w != victim && valid[base + w] && rank[base + w] > r)
							rank[base + w] = rank[base + w] - 1;
					rank[e] = 4'(nvalid - 1);
					tags[e] = tag;
					dirty[e] = (f == FUNC_WRITE);
					x.way_used = 3'(victim);
				end
			end
			pending.push_back(x);
		endfunction

		function void check_result(res_t got);
			res_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.hit !== exp.hit) begin
				$display("%0t: hit exp %0d got %0d", $time, exp.hit, got.hit);
				errors++;
			end
			if (got.allocated !== exp.allocated) begin
				$display("%0t: allocated exp %0d got %0d", $time, exp.allocated,
					got.allocated);
				errors++;
			end
			if (got.evict_dirty !== exp.evict_dirty) begin
				$display("%0t: evict_dirty exp %0d got %0d", $time, exp.evict_dirty,
					got.evict_dirty);
				errors++;
			end
			if (got.evict_address !== exp.evict_address) begin
				$display("%0t: evict_address exp %h got %h", $time,
					exp.evict_address, got.evict_address);
				errors++;
			end
			if (got.way_used !== exp.way_used) begin
				$display("%0t: way_used exp %0d got %0d", $time, exp.way_used,
					got.way_used);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [4:0]  cfg_data = '0;
	logic        in_valid = 0;
	logic        in_ready;
	logic        func = 0;
	logic [31:0] address = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic        hit, allocated, evict_dirty;
	logic [31:0] evict_address;
	logic [2:0]  way_used;

	cache_scoreboard sb = new();
	int tx_pct = 0;   // percent of cycles the request side idles
	int rx_pct = 0;   // percent of cycles the result side stalls
	int cycles = 0;

	set_assoc_lru_cache_controller dut (.*);

	always #1 clk = ~clk;

	// Result side: stall at random, check every accepted result.
	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.hit = hit;
				got.allocated = allocated;
				got.evict_dirty = evict_dirty;
				got.evict_address = evict_address;
				got.way_used = way_used;
				sb.check_result(got);
			end
			out_ready <= ($urandom_range(99) >= rx_pct);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Present one request; return in the time step of the edge that took it.
	task automatic send_req(input logic f, input logic [31:0] a);
		while ($urandom_range(99) < tx_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		func <= f;
		address <= a;
		do @(posedge clk); while (!in_ready);
		sb.note_request(f, a);
	endtask

	// Hold until every queued outcome has come back, then let the pipe settle.
	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four registers back to back; only called while idle.
	task automatic configure(input logic [4:0] ob, input logic [3:0] sbits,
			input logic [1:0] wb, input logic wa);
		logic [1:0] idx [4] = '{CFG_OFFSET_BITS, CFG_SET_BITS, CFG_WAY_BITS,
			CFG_WRITE_ALLOC};
		logic [4:0] val [4];
		val = '{ob, 5'(sbits), 5'(wb), 5'(wa)};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			sb.set_reg(idx[i], val[i]);
		end
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// Pick an address: mostly a few tags in a few sets so lines collide,
	// some with tags near all ones, the rest fully random.
	function automatic logic [31:0] pick_addr();
		int ob, sbits, pick;
		logic [31:0] tag, set, off;
		ob = sb.offset_r > 16 ? 16 : sb.offset_r;
		sbits = sb.sets_r > 8 ? 8 : sb.sets_r;
		pick = $urandom_range(99);
		if (pick >= 70) return $urandom();
		tag = $urandom_range(0, 5);
		if (pick >= 45) tag = (32'hFFFF_FFFF >> (ob + sbits)) - tag;
		set = $urandom_range(0, 3) & ((1 << sbits) - 1);
		off = $urandom() & ((1 << ob) - 1);
		return 32'((64'(tag) << (ob + sbits)) | (set << ob) | off);
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset geometry, 32-byte lines, 64 sets, 2 ways.
		configure(RST_OFFSET_BITS, RST_SET_BITS, RST_WAY_BITS, RST_WRITE_ALLOC);
		send_req(FUNC_READ, 32'h0000_0000);   // fill way 0
		send_req(FUNC_READ, 32'h0000_0800);   // fill way 1
		send_req(FUNC_READ, 32'h0000_001F);   // hit way 0
		send_req(FUNC_WRITE, 32'h0000_0804);  // write hit, dirty
		send_req(FUNC_READ, 32'h0000_1000);   // clean victim
		send_req(FUNC_READ, 32'h0000_0000);   // dirty victim written back
		send_req(FUNC_WRITE, 32'hFFFF_FFFF);  // write miss allocates
		send_req(FUNC_WRITE, 32'hFFFF_FFE0);  // same line, hit
		send_req(FUNC_READ, 32'hFFFF_F7E0);   // fill other way
		send_req(FUNC_READ, 32'h7FFF_FFE0);   // evict dirty all-ones line
		send_req(FUNC_READ, 32'hAAAA_5555);
		send_req(FUNC_WRITE, 32'h5555_AAAA);
		drain();
		// Write miss without allocation leaves the set untouched.
		configure(RST_OFFSET_BITS, RST_SET_BITS, RST_WAY_BITS, 1'b0);
		send_req(FUNC_WRITE, 32'h1234_5678);
		send_req(FUNC_WRITE, 32'h1234_5678);
		send_req(FUNC_WRITE, 32'h5555_AAAA);  // hit still marks dirty
		send_req(FUNC_READ, 32'h1234_5678);   // read miss still allocates
		drain();

		// Random phases: sweep geometry extremes and idle patterns.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure(5'd5, 4'd2, 2'd2, 1'b1);
				1: configure(5'd0, 4'd0, 2'd3, 1'b0);
				2: configure(5'd31, 4'd15, 2'd1, 1'b1);
				3: configure(MAX_OFFSET_BITS, 4'd8, 2'd0, 1'b0);
				4: configure(5'($urandom_range(31)), 4'($urandom_range(15)),
					2'($urandom_range(3)), 1'($urandom_range(1)));
				default: configure(5'd3, 4'd1, 2'd3, 1'b1);
			endcase
			tx_pct = ph < 2 ? 37 : (ph < 4 ? 79 : 0);
			rx_pct = ph < 2 ? 79 : (ph < 4 ? 37 : 0);
			for (int i = 0; i < 100; i++) begin
				if (i == 50) drain();   // hold until all outcomes are back
				send_req(1'($urandom_range(1)), pick_addr());
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
